FILE: sv/bps_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bps_pkg
// Shared types and constants of the buzzer pattern sequencer.
// ----------------------------------------------------------------------------
package bps_pkg;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_START = 2'd1,
		CMD_STOP  = 2'd2,
		CMD_PULSE = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		REG_VOLUME     = 3'd0,
		REG_PAIR_COUNT = 3'd1,
		REG_DURATION_0 = 3'd2,
		REG_DURATION_1 = 3'd3,
		REG_DURATION_2 = 3'd4,
		REG_DURATION_3 = 3'd5,
		REG_DURATION_4 = 3'd6,
		REG_DURATION_5 = 3'd7
	} reg_idx_t;

	localparam int NUM_DUR_REGS = 6;
	localparam int ADDR_W       = 5;
	localparam int LEVEL_W      = 8;
	localparam int PAIR_W       = 2;
	localparam int DUR_W        = 16;
	localparam int ELAPSED_W    = 17;
	localparam int IDX_W        = 3;

	localparam logic [LEVEL_W-1:0]   VOLUME_RESET = 8'hFF;
	localparam logic [PAIR_W-1:0]    PAIR_RESET   = 2'd1;
	localparam logic [DUR_W-1:0]     DUR_RESET    = 16'd500;
	localparam logic [ELAPSED_W-1:0] ELAPSED_MAX  = 17'h1FFFF;

	typedef struct packed {
		logic [LEVEL_W-1:0] volume;
		logic [IDX_W-1:0]   step_count;
	} cfg_view_t;

	typedef struct packed {
		logic               pulse_running;
		logic               pattern_on;
		logic               pattern_running;
		logic [LEVEL_W-1:0] drive_level;
	} result_t;

endpackage
`default_nettype wire

FILE: sv/bps_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bps_regs
// Configuration registers behind the APB port, with step duration lookup.
// ----------------------------------------------------------------------------
module bps_regs #(
	parameter int MAX_STEPS = 6
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [bps_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [31:0]                  pwdata,
	output logic      [31:0]                  prdata,
	input  wire logic [bps_pkg::IDX_W-1:0]    step_idx,
	output bps_pkg::cfg_view_t                cfg,
	output logic      [bps_pkg::DUR_W-1:0]    step_dur
);
	import bps_pkg::*;

	localparam int NumDur  = (MAX_STEPS < NUM_DUR_REGS) ? MAX_STEPS : NUM_DUR_REGS;
	localparam int DurIdxW = (NumDur > 1) ? $clog2(NumDur) : 1;

	logic [LEVEL_W-1:0] volume_q;
	logic [PAIR_W-1:0]  pair_count_q;
	logic [DUR_W-1:0]   dur_q [NumDur];

	reg_idx_t         wr_idx;
	logic             wr_en;
	logic [IDX_W-1:0] dur_sel;
	logic [PAIR_W-1:0] pc_eff;
	logic [IDX_W-1:0] steps_raw;

	assign wr_idx  = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en   = psel && penable && pwrite;
	assign dur_sel = paddr[ADDR_W-1:2] - IDX_W'(REG_DURATION_0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			volume_q     <= VOLUME_RESET;
			pair_count_q <= PAIR_RESET;
			for (int i = 0; i < NumDur; i++) begin
				dur_q[i] <= DUR_RESET;
			end
		end else if (wr_en) begin
			unique case (wr_idx)
				REG_VOLUME:     volume_q     <= pwdata[LEVEL_W-1:0];
				REG_PAIR_COUNT: pair_count_q <= pwdata[PAIR_W-1:0];
				default: begin
					if (32'(dur_sel) < NumDur) begin
						dur_q[dur_sel[DurIdxW-1:0]] <= pwdata[DUR_W-1:0];
					end
				end
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (wr_idx)
			REG_VOLUME:     prdata = 32'(volume_q);
			REG_PAIR_COUNT: prdata = 32'(pair_count_q);
			default: begin
				if (32'(dur_sel) < NumDur) begin
					prdata = 32'(dur_q[dur_sel[DurIdxW-1:0]]);
				end
			end
		endcase
	end

	// zero pairs count as one; cap the step count at MAX_STEPS
	assign pc_eff    = (pair_count_q == '0) ? PAIR_W'(1) : pair_count_q;
	assign steps_raw = {pc_eff, 1'b0};

	always_comb begin
		cfg.volume     = volume_q;
		cfg.step_count = (32'(steps_raw) > MAX_STEPS) ? IDX_W'(MAX_STEPS) : steps_raw;
		if (32'(step_idx) < NumDur) begin
			step_dur = dur_q[step_idx[DurIdxW-1:0]];
		end else if (32'(step_idx) < MAX_STEPS) begin
			step_dur = DUR_RESET;
		end else begin
			step_dur = '0;
		end
	end

endmodule
`default_nettype wire

FILE: sv/buzzer_pattern_sequencer_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// buzzer_pattern_sequencer_top
// Buzzer level sequencer: cyclic on/off pattern plus a one-shot pulse.
// ----------------------------------------------------------------------------
// Each request on the slave stream is one command (tick, start, stop, pulse)
// and yields exactly one result on the master stream, carrying the drive level
// and the three status flags after the command has taken effect. A request is
// registered in the s1 stage register and its result in the output register;
// one request is taken every cycle while the master side does not stall; the state
// update and the output register share a single stall condition, the master
// side being free or emptied in that cycle. Configuration writes go through
// the APB port with pready tied high; a new volume shows only at the next
// level write, while durations and pair count apply from the next tick.
// ----------------------------------------------------------------------------
module buzzer_pattern_sequencer_top #(
	parameter int MAX_STEPS = 6
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [bps_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                pwdata,
	output logic      [31:0]                prdata,
	output logic                            pready,
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	input  wire logic [15:0]                s_tdata,  // [15:0] pulse_len
	input  wire logic [1:0]                 s_tuser,  // [1:0] command
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	output logic      [15:0]                m_tdata   // [7:0] drive_level, [8] pattern_running,
	                                                  // [9] pattern_on, [10] pulse_running
);
	import bps_pkg::*;

	logic             valid_s1;
	cmd_t             cmd_s1;
	logic [DUR_W-1:0] plen_s1;
	result_t          result_s2;
	logic             advance;

	logic                 running_q;
	logic                 phase_on_q;
	logic [IDX_W-1:0]     step_index_q;
	logic [ELAPSED_W-1:0] step_elapsed_q;
	logic                 pulse_q;
	logic [ELAPSED_W-1:0] pulse_elapsed_q;
	logic [DUR_W-1:0]     pulse_limit_q;
	logic [LEVEL_W-1:0]   level_q;

	logic                 running_d;
	logic                 phase_on_d;
	logic [IDX_W-1:0]     step_index_d;
	logic [ELAPSED_W-1:0] step_elapsed_d;
	logic                 pulse_d;
	logic [ELAPSED_W-1:0] pulse_elapsed_d;
	logic [DUR_W-1:0]     pulse_limit_d;
	logic [LEVEL_W-1:0]   level_d;

	logic [ELAPSED_W-1:0] step_inc;
	logic [ELAPSED_W-1:0] pulse_inc;
	logic [IDX_W:0]       next_idx;

	cfg_view_t        cfg;
	logic [DUR_W-1:0] step_dur;

	bps_regs #(
		.MAX_STEPS(MAX_STEPS)
	) u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.step_idx (step_index_q),
		.cfg      (cfg),
		.step_dur (step_dur)
	);

	assign pready   = 1'b1;
	assign advance  = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign m_tdata  = 16'(result_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1  <= cmd_t'(s_tuser);
			plen_s1 <= s_tdata;
		end
	end

	assign step_inc  = (step_elapsed_q == ELAPSED_MAX) ? ELAPSED_MAX : step_elapsed_q + 1'b1;
	assign pulse_inc = (pulse_elapsed_q == ELAPSED_MAX) ? ELAPSED_MAX : pulse_elapsed_q + 1'b1;
	assign next_idx  = {1'b0, step_index_q} + 1'b1;

	always_comb begin
		running_d       = running_q;
		phase_on_d      = phase_on_q;
		step_index_d    = step_index_q;
		step_elapsed_d  = step_elapsed_q;
		pulse_d         = pulse_q;
		pulse_elapsed_d = pulse_elapsed_q;
		pulse_limit_d   = pulse_limit_q;
		level_d         = level_q;
		unique case (cmd_s1)
			CMD_TICK: begin
				pulse_elapsed_d = pulse_inc;
				step_elapsed_d  = step_inc;
				if (pulse_q && (pulse_inc > {1'b0, pulse_limit_q})) begin
					pulse_d = 1'b0;
					level_d = '0;
				end
				if (running_q && (step_inc > {1'b0, step_dur})) begin
					step_elapsed_d = '0;
					phase_on_d     = !phase_on_q;
					level_d        = phase_on_q ? '0 : cfg.volume;
					step_index_d   = (next_idx >= {1'b0, cfg.step_count}) ? '0
					                 : next_idx[IDX_W-1:0];
				end
			end
			CMD_START: begin
				if (!running_q) begin
					running_d      = 1'b1;
					step_elapsed_d = '0;
					step_index_d   = '0;
					phase_on_d     = 1'b1;
					level_d        = cfg.volume;
				end
			end
			CMD_STOP: begin
				if (running_q) begin
					running_d      = 1'b0;
					step_elapsed_d = '0;
					step_index_d   = '0;
					phase_on_d     = 1'b0;
					level_d        = '0;
				end
			end
			CMD_PULSE: begin
				pulse_elapsed_d = '0;
				pulse_d         = 1'b1;
				pulse_limit_d   = plen_s1;
				level_d         = cfg.volume;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q       <= 1'b0;
			phase_on_q      <= 1'b0;
			step_index_q    <= '0;
			step_elapsed_q  <= '0;
			pulse_q         <= 1'b0;
			pulse_elapsed_q <= '0;
			pulse_limit_q   <= '0;
			level_q         <= '0;
		end else if (advance) begin
			running_q       <= running_d;
			phase_on_q      <= phase_on_d;
			step_index_q    <= step_index_d;
			step_elapsed_q  <= step_elapsed_d;
			pulse_q         <= pulse_d;
			pulse_elapsed_q <= pulse_elapsed_d;
			pulse_limit_q   <= pulse_limit_d;
			level_q         <= level_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2.drive_level     <= level_d;
			result_s2.pattern_running <= running_d;
			result_s2.pattern_on      <= phase_on_d;
			result_s2.pulse_running   <= pulse_d;
		end
	end

`ifndef ASSERT_OFF
	a_phase_needs_run: assert property (@(posedge clk) disable iff (!arst_n)
		phase_on_q |-> running_q)
		else $error("on phase without a running pattern");

	a_idle_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!running_q |-> (step_index_q == '0))
		else $error("step index not cleared while stopped");

	a_index_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		32'(step_index_q) < MAX_STEPS)
		else $error("step index beyond table");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_tvalid)
		else $error("request advanced without a result");
`endif

endmodule
`default_nettype wire
